// ===== rtl/djb2_pkg.sv =====
// Shared types and constants for the djb2 bucket index block.
// No dependencies; imported by every module of the block.
package djb2_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BUCKET_W = 32;

  // djb2 seed, multiplier shift (x33 = x<<5 + x) and the key-name stop byte
  localparam logic [31:0]       SEED      = 32'd5381;
  localparam int unsigned       MUL_SHIFT = 5;
  localparam logic [BYTE_W-1:0] EQ_BYTE   = 8'h3D;
  localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;

  // configuration register indexes
  localparam logic REG_MODE       = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  // status of the shared remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

// ===== rtl/djb2_mod_unit.sv =====
// Iterative remainder unit: one shift-and-subtract step per cycle.
// Depends on djb2_pkg. A zero divisor is taken as 2^32 (low bits returned).
module djb2_mod_unit #(
  parameter int unsigned DVD_W = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DVD_W-1:0]              dividend,
  input  logic [djb2_pkg::BUCKET_W-1:0] divisor,
  output djb2_pkg::mod_status_t         status,
  output logic [djb2_pkg::BUCKET_W-1:0] remainder
);
  import djb2_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  typedef enum logic [1:0] {
    M_IDLE = 2'b01,
    M_RUN  = 2'b10
  } mod_state_t;

  mod_state_t          state_r, state_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [BUCKET_W-1:0] dsr_r, dsr_nxt;
  logic [BUCKET_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                done_r, done_nxt;

  logic [BUCKET_W:0] shifted;
  logic [BUCKET_W:0] diff;

  // restoring step: bring in the next dividend bit, subtract if it fits
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    dsr_nxt   = dsr_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          dsr_nxt = divisor;
          if (divisor == '0) begin
            rem_nxt  = dividend[BUCKET_W-1:0];
            done_nxt = 1'b1;
          end else begin
            dvd_nxt   = dividend;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(DVD_W);
            state_nxt = M_RUN;
          end
        end
      end
      M_RUN: begin
        rem_nxt = diff[BUCKET_W] ? shifted[BUCKET_W-1:0] : diff[BUCKET_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign status.busy = (state_r == M_RUN);
  assign status.done = done_r;
  assign remainder   = rem_r;

endmodule

// ===== rtl/djb2_bucket_index_unit.sv =====
// Streaming djb2 hash with bucket reduction: one key byte a cycle, result
// at key end, once the remainder unit is done. Throughput: one byte a cycle
// inside a key; each key end holds the input while the bit-per-cycle
// remainder loop runs and until the output slot is free. Synchronous
// active-low reset clears the accumulator to the seed, registers to mode 0 /
// table_size 1, no pending result.
module djb2_bucket_index_unit #(
  parameter int unsigned HASH_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key_byte
  input  logic        in_tlast,   // last byte of the key
  // result requests
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] bucket
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import djb2_pkg::*;

  typedef enum logic [2:0] {
    S_ACC  = 3'b001,  // taking key bytes
    S_WAIT = 3'b010,  // remainder unit running
    S_PUSH = 3'b100   // result held, output slot still full
  } state_t;

  state_t                state_r, state_nxt;
  logic [HASH_WIDTH-1:0] acc_r, acc_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  mode_r;
  logic [BUCKET_W-1:0]   tsize_r;
  logic [BUCKET_W-1:0]   res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BUCKET_W-1:0]   out_data_r, out_data_nxt;

  logic                  in_fire;
  logic                  stop_now;
  logic                  hash_byte;
  logic [HASH_WIDTH-1:0] acc_step;
  logic [HASH_WIDTH-1:0] byte_ext;
  logic [HASH_WIDTH-1:0] acc_upd;
  logic                  out_free;
  logic                  mod_start;
  mod_status_t           mod_st;
  logic [BUCKET_W-1:0]   mod_rem;
  logic [BUCKET_W-1:0]   bucket;

  assign in_tready = (state_r == S_ACC);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // key-name mode: a NUL or '=' byte stops hashing until the key ends
  assign stop_now  = !stopped_r && mode_r && ((in_tdata == NUL_BYTE) || (in_tdata == EQ_BYTE));
  assign hash_byte = !stopped_r && !stop_now;

  // acc*33 + signed byte, wrapping at HASH_WIDTH bits
  assign byte_ext = {{(HASH_WIDTH-BYTE_W){in_tdata[BYTE_W-1]}}, in_tdata};
  assign acc_step = (acc_r << MUL_SHIFT) + acc_r + byte_ext;
  assign acc_upd  = hash_byte ? acc_step : acc_r;

  assign mod_start = in_fire && in_tlast;

  // a remainder of zero maps to bucket one
  assign bucket = (mod_rem == '0) ? BUCKET_W'(1) : mod_rem;

  djb2_mod_unit #(
    .DVD_W (HASH_WIDTH)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (acc_upd),
    .divisor   (tsize_r),
    .status    (mod_st),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    stopped_nxt   = stopped_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_ACC: begin
        if (in_fire) begin
          if (in_tlast) begin
            acc_nxt     = HASH_WIDTH'(SEED);
            stopped_nxt = 1'b0;
            state_nxt   = S_WAIT;
          end else begin
            acc_nxt     = acc_upd;
            stopped_nxt = stopped_r || stop_now;
          end
        end
      end
      S_WAIT: begin
        if (mod_st.done) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = bucket;
            state_nxt     = S_ACC;
          end else begin
            res_nxt   = bucket;
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      acc_r       <= HASH_WIDTH'(SEED);
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      tsize_r     <= BUCKET_W'(1);
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:       mode_r  <= cfg_wdata[0];
          REG_TABLE_SIZE: tsize_r <= cfg_wdata;
          default:        ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== test/tb_djb2_bucket_index_unit.sv =====
// Self-checking testbench for djb2_bucket_index_unit: streamed key bytes in,
// bucket indexes out, each checked against an in-bench djb2 predictor.
// Depends on the rtl/ sources: djb2_pkg, djb2_mod_unit and the top level.
`timescale 1ns / 1ps

module tb_djb2_bucket_index_unit;
  import djb2_pkg::*;

  localparam int unsigned HASH_W        = 64;
  // long enough for a key end's run through the remainder loop, plus slack
  localparam int unsigned SETTLE_CYCLES = HASH_W + 8;
  // longest stretch without any request moving; far above a correct run's worst
  // case (key end + long receiver stall + idle settle before a register write)
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_end;
  } key_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] key_byte
  logic        in_tlast = 1'b0;  // last byte of the key
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [31:0] bucket
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_MODE;
  logic [31:0] cfg_wdata = '0;

  // requests waiting for the driver, buckets waiting for the monitor
  key_req_t    key_bytes_q[$];
  logic [31:0] bucket_q[$];

  // predictor state and its copy of the registers
  logic [63:0] hash_acc;
  logic        key_stopped;
  logic        cur_mode;
  logic [31:0] cur_table_size;

  int unsigned send_gap_pct = 22;
  int unsigned recv_stall_pct = 65;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  djb2_bucket_index_unit #(.HASH_WIDTH(HASH_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // single reset at the start
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Predictor: one key byte under the mode in force now. Once a stop byte has
  // been seen in key-name mode the rest of the key is ignored, even if the mode
  // is switched back mid-key. Pushes the bucket on the key's final byte.
  task automatic absorb_key_byte(input logic [7:0] kb, input logic fin);
    logic [63:0] rem;
    if (!key_stopped && cur_mode && (kb == NUL_BYTE || kb == EQ_BYTE))
      key_stopped = 1'b1;
    if (!key_stopped)
      hash_acc = (hash_acc << MUL_SHIFT) + hash_acc + {{56{kb[7]}}, kb};
    if (fin) begin
      // a table size of zero stands for 2^32 buckets
      if (cur_table_size == '0)
        rem = {32'd0, hash_acc[31:0]};
      else
        rem = hash_acc % {32'd0, cur_table_size};
      if (rem == '0)
        rem = 64'd1;
      bucket_q.push_back(rem[31:0]);
      hash_acc = 64'(SEED);
      key_stopped = 1'b0;
    end
  endtask

  // Driver: holds a request until taken, may idle between requests
  always @(posedge clk) begin
    key_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (key_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        req = key_bytes_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.key_byte;
        in_tlast  <= req.key_end;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n)
      out_tready <= 1'b0;
    else
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: follows register writes, predicts on every accepted key byte,
  // checks every accepted bucket against the oldest prediction
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      hash_acc       = 64'(SEED);
      key_stopped    = 1'b0;
      cur_mode       = 1'b0;
      cur_table_size = 32'd1;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE)
          cur_mode = cfg_wdata[0];
        else
          cur_table_size = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (bucket_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected bucket %0d, nothing pending", $realtime, out_tdata);
        end else begin
          want = bucket_q.pop_front();
          if (out_tdata !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: bucket mismatch, expected %0d got %0d",
                       $realtime, want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready)
        absorb_key_byte(in_tdata, in_tlast);
    end
  end

  // Watchdog: any request moving, or a register write, counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[djb2_bucket_index_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] kb, input logic fin);
    key_bytes_q.push_back('{key_byte: kb, key_end: fin});
  endtask

  // sender holds off until every queued byte is in and every bucket is out
  task automatic drain();
    @(negedge clk);
    while (key_bytes_q.size() != 0 || in_tvalid || bucket_q.size() != 0)
      @(negedge clk);
  endtask

  // drain, then let the remainder loop finish before touching a register
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic reconfigure(input logic md, input logic [31:0] tsize);
    settle();
    write_reg(REG_MODE, 32'(md));
    write_reg(REG_TABLE_SIZE, tsize);
  endtask

  // plenty of stop bytes and printable text, the rest fully random
  function automatic logic [7:0] pick_key_byte();
    case ($urandom_range(0, 9))
      0:          return NUL_BYTE;
      1:          return EQ_BYTE;
      2, 3, 4, 5: return 8'($urandom_range(8'h20, 8'h7E));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // whole keys, mostly short; now and then the sender waits for all buckets
  task automatic random_keys(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < len; i++)
        push_byte(pick_key_byte(), i == len - 1);
      sent += len;
      if ($urandom_range(0, 24) == 0)
        drain();
    end
  endtask

  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);

    // reset registers: one bucket, remainder zero comes out as 1
    push_byte(8'h61, 1'b1);

    // largest nonzero table size, sign-extended bytes at both ends of the range
    reconfigure(1'b0, 32'hFFFF_FFFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hFF, 1'b1);

    // key-name mode with a zero table size (low 32 bits of the hash)
    reconfigure(1'b1, 32'd0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(EQ_BYTE, 1'b0);
    push_byte(8'h63, 1'b0);
    push_byte(8'h64, 1'b1);
    push_byte(8'h41, 1'b0);
    push_byte(NUL_BYTE, 1'b0);
    push_byte(8'h42, 1'b1);
    push_byte(EQ_BYTE, 1'b1);      // stop byte is the whole key
    push_byte(8'h41, 1'b0);
    push_byte(EQ_BYTE, 1'b1);      // stop byte on the final step

    // mode switched to plain inside an open key: stop byte now hashed
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    settle();
    write_reg(REG_MODE, 32'd0);
    push_byte(EQ_BYTE, 1'b0);
    push_byte(8'h43, 1'b1);

    // a key already stopped stays stopped after leaving key-name mode
    settle();
    write_reg(REG_MODE, 32'd1);
    push_byte(8'h41, 1'b0);
    push_byte(EQ_BYTE, 1'b0);
    settle();
    write_reg(REG_MODE, 32'd0);
    push_byte(8'h44, 1'b0);
    push_byte(8'h45, 1'b1);

    // random keys: sender idles 22%, receiver 65%
    reconfigure(1'b0, $urandom());
    random_keys(140);
    reconfigure(1'b1, 32'hFFFF_FFFF);
    random_keys(140);

    // roles swapped
    settle();
    send_gap_pct   = 65;
    recv_stall_pct = 22;
    reconfigure(1'b0, $urandom_range(1, 16));
    random_keys(140);
    reconfigure(1'b1, $urandom());
    random_keys(140);

    // no idling on either side
    settle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    reconfigure(1'b0, 32'd0);
    random_keys(140);
    reconfigure(1'b1, $urandom_range(1, 1000));
    random_keys(140);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bucket_q.size() != 0) begin
      fail_count += bucket_q.size();
      $display("%0d buckets never arrived", bucket_q.size());
    end
    if (fail_count == 0)
      $display("[djb2_bucket_index_unit] OK");
    else
      $display("[djb2_bucket_index_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/djb2_pkg.sv
rtl/djb2_mod_unit.sv
rtl/djb2_bucket_index_unit.sv
test/tb_djb2_bucket_index_unit.sv
